// ===== hdl/wanf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wanf_pkg;

  // operation codes of one command beat
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_FIND    = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  // one stored alarm
  typedef struct packed {
    logic        once;
    logic        en;
    logic [6:0]  mask;
    logic [17:0] hms;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clear;
    logic append;
    logic scan_init;
    logic scan_issue;
    logic dis_read;
    logic dis_write;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic scan_done;
    logic pipe_busy;
  } stat_t;

  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [2:0]  LastDay    = 3'd6;

  // reciprocal constants for the divisions by 100 of the hhmmss digits
  localparam logic [18:0] Recip100Wide   = 19'd335545;  // shift by 25
  localparam logic [12:0] Recip100Narrow = 13'd5243;    // shift by 19

  // mask bit of a weekday, bit 6 is Sunday; no bit for day seven
  function automatic logic day_bit(input logic [6:0] mask, input logic [2:0] day);
    logic       hit;
    logic [2:0] pos;
    hit = 1'b0;
    pos = 3'd0;
    if (day <= LastDay) begin
      pos = LastDay - day;
      hit = mask[pos];
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/weekly_alarm_next_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Weekly alarm table with a next-alarm search.
// Command channel: a beat is taken at a rising edge with start high and busy
// low; in_operation picks clear, append, find next or disable one-shot, and
// the other in_ fields give that command's operands.
// Result channel: every command gives one result beat, held on the out_
// ports for a single cycle while out_strobe is high. The receiver cannot
// stall, so results are never held back.
// Clear and append complete in the execute state; disable reads the entry,
// then writes it back; find next scans the N stored entries: the search
// reads one entry a cycle from the table RAM through a five-stage time
// conversion pipeline, then waits for it to drain. Disabled entries leave
// the pipeline after the read, so those at the end of the table drain early.
// One command is in flight at a time, so the next start is taken in the
// cycle the strobe is high.
// Reset empties the table (count to zero) and idles the controller; stored
// entries are only read below the count, so the RAM needs no clearing.

module weekly_alarm_next_finder #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [17:0] in_entry_time,
  input  wire logic [6:0]  in_repeat_mask,
  input  wire logic        in_entry_enabled,
  input  wire logic        in_entry_once,
  input  wire logic [16:0] in_now_seconds,
  input  wire logic [2:0]  in_weekday,
  input  wire logic [4:0]  in_trigger_index,
  input  wire logic        in_trigger_once,
  output logic             out_strobe,
  output logic             out_found,
  output logic [17:0]      out_alarm_time,
  output logic             out_alarm_once,
  output logic [4:0]       out_alarm_index,
  output logic             out_accepted
);

  wanf_pkg::cmd_t  cmd;
  wanf_pkg::stat_t st;

  wanf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  wanf_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_operation     (in_operation),
    .in_entry_time    (in_entry_time),
    .in_repeat_mask   (in_repeat_mask),
    .in_entry_enabled (in_entry_enabled),
    .in_entry_once    (in_entry_once),
    .in_now_seconds   (in_now_seconds),
    .in_weekday       (in_weekday),
    .in_trigger_index (in_trigger_index),
    .in_trigger_once  (in_trigger_once),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_alarm_time   (out_alarm_time),
    .out_alarm_once   (out_alarm_once),
    .out_alarm_index  (out_alarm_index),
    .out_accepted     (out_accepted)
  );

endmodule

`default_nettype wire

// ===== hdl/wanf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wanf_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AddrW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [AddrW-1:0]         raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wanf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wanf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire wanf_pkg::stat_t st,
  output wanf_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_DIS
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.op)
          wanf_pkg::OP_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
          wanf_pkg::OP_APPEND: begin
            cmd.append = 1'b1;
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
          wanf_pkg::OP_FIND: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          default: begin
            cmd.dis_read = 1'b1;
            state_nxt    = S_DIS;
          end
        endcase
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!st.pipe_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIS: begin
        cmd.dis_write = 1'b1;
        cmd.finish    = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== hdl/wanf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wanf_dp #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wanf_pkg::cmd_t  cmd,
  output wanf_pkg::stat_t      st,
  input  wire logic [1:0]      in_operation,
  input  wire logic [17:0]     in_entry_time,
  input  wire logic [6:0]      in_repeat_mask,
  input  wire logic            in_entry_enabled,
  input  wire logic            in_entry_once,
  input  wire logic [16:0]     in_now_seconds,
  input  wire logic [2:0]      in_weekday,
  input  wire logic [4:0]      in_trigger_index,
  input  wire logic            in_trigger_once,
  output logic                 out_strobe,
  output logic                 out_found,
  output logic [17:0]          out_alarm_time,
  output logic                 out_alarm_once,
  output logic [4:0]           out_alarm_index,
  output logic                 out_accepted
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW = (CW > 5) ? CW : 5;

  // fields that ride along the scan pipeline
  typedef struct packed {
    logic          once;
    logic [6:0]    mask;
    logic [17:0]   hms;
    logic [AW-1:0] idx;
  } meta_t;

  // latched command beat
  wanf_pkg::op_t    op_r;
  wanf_pkg::entry_t new_entry_r;
  logic [16:0]      now_r;
  logic [2:0]       wd_r;
  logic [4:0]       trig_idx_r;
  logic             trig_once_r;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    scan_addr_r;

  // table memory
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  wanf_pkg::entry_t ram_wdata, ram_rdata;

  // scan pipeline
  logic          v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] idx0_r;
  meta_t         m1_r, m2_r, m3_r, m4_r;
  logic [36:0]   prod1_r;
  logic [11:0]   q1_r;
  logic [6:0]    ss2_r, ss3_r;
  logic [23:0]   prod2_r;
  logic [4:0]    q2_r;
  logic [6:0]    mm_r;
  logic [16:0]   sec_r;

  // best candidate so far
  logic          have_r;
  logic [17:0]   best_r;
  meta_t         best_m_r;

  // result registers
  logic          strobe_r, found_r, once_out_r, acc_r;
  logic [17:0]   time_out_r;
  logic [4:0]    idx_out_r;

  logic          full;
  logic          dis_hit;
  logic [11:0]   q1_nxt;
  logic [6:0]    ss_nxt;
  logic [4:0]    q2_nxt;
  logic [16:0]   sec_nxt;
  logic [2:0]    tom_day;
  logic          today_hit, tom_hit;
  logic [17:0]   sec_ext, cand;
  logic          cand_ok, take;

  assign full = (count_r >= CW'(MAX_ENTRIES));

  assign st.op        = op_r;
  assign st.scan_done = (scan_addr_r >= count_r);
  assign st.pipe_busy = v0_r | v1_r | v2_r | v3_r | v4_r;

  // drop the enable bit of a valid one-shot entry
  assign dis_hit = trig_once_r && (IW'(trig_idx_r) < IW'(count_r)) && ram_rdata.once;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count_r);
    ram_wdata = new_entry_r;
    if (cmd.append && !full) begin
      ram_we = 1'b1;
    end else if (cmd.dis_write && dis_hit) begin
      ram_we       = 1'b1;
      ram_waddr    = AW'(trig_idx_r);
      ram_wdata    = ram_rdata;
      ram_wdata.en = 1'b0;
    end
  end

  assign ram_re    = cmd.scan_issue | cmd.dis_read;
  assign ram_raddr = cmd.dis_read ? AW'(trig_idx_r) : AW'(scan_addr_r);

  wanf_ram #(
    .WIDTH ($bits(wanf_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // split hhmmss into digits: seconds and the quotient by 100
  assign q1_nxt = prod1_r[36:25];
  assign ss_nxt = 7'(m1_r.hms - 18'(q1_nxt) * 18'd100);
  assign q2_nxt = prod2_r[23:19];
  assign sec_nxt = 17'(q2_r) * 17'd3600 + 17'(mm_r) * 17'd60 + 17'(ss3_r);

  // candidate of the entry at the end of the pipeline
  always_comb begin
    // wrap Saturday to Sunday; day seven wraps to Monday
    if (wd_r == wanf_pkg::LastDay) begin
      tom_day = 3'd0;
    end else if (wd_r > wanf_pkg::LastDay) begin
      tom_day = 3'd1;
    end else begin
      tom_day = wd_r + 3'd1;
    end
    today_hit = wanf_pkg::day_bit(m4_r.mask, wd_r);
    tom_hit   = wanf_pkg::day_bit(m4_r.mask, tom_day);
    sec_ext   = {1'b0, sec_r};
    cand      = sec_ext + {1'b0, wanf_pkg::SecsPerDay};
    cand_ok   = 1'b1;
    if (m4_r.once) begin
      if (sec_r >= now_r) begin
        cand = sec_ext;
      end
    end else if (today_hit && (sec_r >= now_r)) begin
      cand = sec_ext;
    end else if (!tom_hit) begin
      cand_ok = 1'b0;
    end
    take = v4_r && cand_ok && (!have_r || (cand < best_r));
  end

  // latch the beat and keep the table count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && !full) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r             <= wanf_pkg::op_t'(in_operation);
      new_entry_r.hms  <= in_entry_time;
      new_entry_r.mask <= in_repeat_mask;
      new_entry_r.en   <= in_entry_enabled;
      new_entry_r.once <= in_entry_once;
      now_r            <= in_now_seconds;
      wd_r             <= in_weekday;
      trig_idx_r       <= in_trigger_index;
      trig_once_r      <= in_trigger_once;
    end
  end

  // advance the scan address and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_addr_r <= scan_addr_r + CW'(1);
      end
      v0_r <= cmd.scan_issue;
      v1_r <= v0_r && ram_rdata.en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.scan_init) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    idx0_r       <= AW'(scan_addr_r);
    m1_r.once    <= ram_rdata.once;
    m1_r.mask    <= ram_rdata.mask;
    m1_r.hms     <= ram_rdata.hms;
    m1_r.idx     <= idx0_r;
    prod1_r      <= 37'(ram_rdata.hms) * 37'(wanf_pkg::Recip100Wide);
    m2_r         <= m1_r;
    q1_r         <= q1_nxt;
    ss2_r        <= ss_nxt;
    prod2_r      <= 24'(q1_nxt) * 24'(wanf_pkg::Recip100Narrow);
    m3_r         <= m2_r;
    q2_r         <= q2_nxt;
    mm_r         <= 7'(q1_r - 12'(q2_nxt) * 12'd100);
    ss3_r        <= ss2_r;
    m4_r         <= m3_r;
    sec_r        <= sec_nxt;
    if (take) begin
      best_r   <= cand;
      best_m_r <= m4_r;
    end
  end

  // emit the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found_r    <= 1'b0;
      time_out_r <= '0;
      once_out_r <= 1'b0;
      idx_out_r  <= '0;
      acc_r      <= (op_r == wanf_pkg::OP_APPEND) && !full;
      if ((op_r == wanf_pkg::OP_FIND) && have_r) begin
        found_r    <= 1'b1;
        time_out_r <= best_m_r.hms;
        once_out_r <= best_m_r.once;
        idx_out_r  <= 5'(best_m_r.idx);
      end
    end
  end

  assign out_strobe      = strobe_r;
  assign out_found       = found_r;
  assign out_alarm_time  = time_out_r;
  assign out_alarm_once  = once_out_r;
  assign out_alarm_index = idx_out_r;
  assign out_accepted    = acc_r;

endmodule

`default_nettype wire

// ===== sim/weekly_alarm_next_finder_tb.sv =====
`timescale 1ns / 1ps

module weekly_alarm_next_finder_tb;
  import wanf_pkg::*;

  localparam int MaxEntries = 32;
  localparam int unsigned DaySecs = 86400;

  // one command beat, one field per input port
  typedef struct packed {
    op_t         op;
    logic [17:0] etime;
    logic [6:0]  mask;
    logic        en;
    logic        once;
    logic [16:0] now;
    logic [2:0]  wday;
    logic [4:0]  tidx;
    logic        tonce;
  } alarm_beat_t;

  // one result beat
  typedef struct packed {
    logic        found;
    logic [17:0] alarm_time;
    logic        alarm_once;
    logic [4:0]  alarm_index;
    logic        accepted;
  } alarm_result_t;

  // directed row: beat plus an optional hand-written result
  typedef struct {
    alarm_beat_t   beat;
    bit            typed;
    alarm_result_t want;
  } stim_row_t;

  localparam alarm_result_t NoResult = '0;
  localparam alarm_result_t AppendOk = '{found: 1'b0, alarm_time: 18'd0, alarm_once: 1'b0,
                                         alarm_index: 5'd0, accepted: 1'b1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = 2'd0;
  logic [17:0] in_entry_time = '0;
  logic [6:0]  in_repeat_mask = '0;
  logic        in_entry_enabled = 1'b0;
  logic        in_entry_once = 1'b0;
  logic [16:0] in_now_seconds = '0;
  logic [2:0]  in_weekday = '0;
  logic [4:0]  in_trigger_index = '0;
  logic        in_trigger_once = 1'b0;
  logic        out_strobe;
  logic        out_found;
  logic [17:0] out_alarm_time;
  logic        out_alarm_once;
  logic [4:0]  out_alarm_index;
  logic        out_accepted;

  // travels with the beat so the monitor sees it at the accepting edge
  bit            row_typed = 1'b0;
  alarm_result_t row_want = '0;

  // shadow copy of the alarm table
  entry_t shadow_table [MaxEntries];
  int     shadow_count = 0;

  alarm_result_t pending_results [$];
  int            fail_count = 0;

  //  op          time       mask   en    once  now         wday  tidx  tonce
  stim_row_t directed_rows [22] = '{
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, NoResult},
    '{'{OP_DISABLE, 18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b1}, 1'b1, NoResult},
    '{'{OP_APPEND,  18'd235959, 7'h7F, 1'b1, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_APPEND,  18'd0,      7'h00, 1'b1, 1'b1, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_APPEND,  18'h3FFFF,  7'h40, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_APPEND,  18'd120000, 7'h01, 1'b1, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_APPEND,  18'd99,     7'h20, 1'b1, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b0, NoResult},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd86399,  3'd6, 5'd0,  1'b0}, 1'b0, NoResult},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'h1FFFF,  3'd7, 5'd0,  1'b0}, 1'b0, NoResult},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd7, 5'd0,  1'b0}, 1'b0, NoResult},
    '{'{OP_DISABLE, 18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd1,  1'b0}, 1'b1, NoResult},
    '{'{OP_DISABLE, 18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b1}, 1'b1, NoResult},
    '{'{OP_DISABLE, 18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd1,  1'b1}, 1'b1, NoResult},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b0, NoResult},
    '{'{OP_DISABLE, 18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd31, 1'b1}, 1'b1, NoResult},
    '{'{OP_CLEAR,   18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, NoResult},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd0,      3'd3, 5'd0,  1'b0}, 1'b1, NoResult},
    '{'{OP_APPEND,  18'd63000,  7'h7F, 1'b1, 1'b0, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_APPEND,  18'd63000,  7'h00, 1'b1, 1'b1, 17'd0,      3'd0, 5'd0,  1'b0}, 1'b1, AppendOk},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd23400,  3'd2, 5'd0,  1'b0}, 1'b0, NoResult},
    '{'{OP_FIND,    18'd0,      7'h00, 1'b0, 1'b0, 17'd23401,  3'd2, 5'd0,  1'b0}, 1'b0, NoResult}
  };

  weekly_alarm_next_finder #(
    .MAX_ENTRIES(MaxEntries)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_entry_time    (in_entry_time),
    .in_repeat_mask   (in_repeat_mask),
    .in_entry_enabled (in_entry_enabled),
    .in_entry_once    (in_entry_once),
    .in_now_seconds   (in_now_seconds),
    .in_weekday       (in_weekday),
    .in_trigger_index (in_trigger_index),
    .in_trigger_once  (in_trigger_once),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_alarm_time   (out_alarm_time),
    .out_alarm_once   (out_alarm_once),
    .out_alarm_index  (out_alarm_index),
    .out_accepted     (out_accepted)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // decimal hhmmss digits to seconds, whatever the digit values
  function automatic int unsigned hms_to_secs(logic [17:0] hms);
    int unsigned v;
    v = hms;
    return (v / 10000) * 3600 + ((v / 100) % 100) * 60 + v % 100;
  endfunction

  // bit 6 is Sunday; day seven matches nothing
  function automatic bit mask_has_day(logic [6:0] mask, int unsigned day);
    if (day > 6) return 1'b0;
    return mask[6 - day];
  endfunction

  // apply one beat to the shadow table and return the alarm it reports
  function automatic alarm_result_t next_alarm_outcome(alarm_beat_t b);
    alarm_result_t r;
    entry_t        e;
    int unsigned   secs, cand, best, tmrw;
    int            best_idx;
    bit            have;
    r = '0;
    best = 0;
    best_idx = 0;
    have = 1'b0;
    case (b.op)
      OP_CLEAR: begin
        shadow_count = 0;
      end
      OP_APPEND: begin
        if (shadow_count < MaxEntries) begin
          shadow_table[shadow_count] = '{once: b.once, en: b.en, mask: b.mask, hms: b.etime};
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      OP_FIND: begin
        tmrw = (int'(b.wday) + 1) % 7;
        for (int i = 0; i < shadow_count; i++) begin
          e = shadow_table[i];
          if (!e.en) continue;
          secs = hms_to_secs(e.hms);
          if (e.once) cand = (secs >= b.now) ? secs : secs + DaySecs;
          else if (mask_has_day(e.mask, b.wday) && secs >= b.now) cand = secs;
          else if (mask_has_day(e.mask, tmrw)) cand = secs + DaySecs;
          else continue;
          if (!have || cand < best) begin
            best = cand;
            best_idx = i;
            have = 1'b1;
          end
        end
        if (have) begin
          r.found = 1'b1;
          r.alarm_time = shadow_table[best_idx].hms;
          r.alarm_once = shadow_table[best_idx].once;
          r.alarm_index = best_idx[4:0];
        end
      end
      OP_DISABLE: begin
        if (b.tonce && b.tidx < shadow_count && shadow_table[b.tidx].once) begin
          shadow_table[b.tidx].en = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // well-formed time of day as hhmmss
  function automatic logic [17:0] pick_hms();
    return 18'($urandom_range(23) * 10000 + $urandom_range(59) * 100 + $urandom_range(59));
  endfunction

  // random beat, mostly meaningful against the current table contents
  function automatic alarm_beat_t random_beat();
    alarm_beat_t b;
    int unsigned pick;
    b.op    = OP_CLEAR;
    b.etime = 18'($urandom());
    b.mask  = 7'($urandom());
    b.en    = 1'($urandom());
    b.once  = 1'($urandom());
    b.now   = 17'($urandom());
    b.wday  = 3'($urandom());
    b.tidx  = 5'($urandom());
    b.tonce = 1'($urandom());
    pick = $urandom_range(99);
    if (pick < 3) begin
      b.op = OP_CLEAR;
    end else if (pick < 38) begin
      b.op = OP_APPEND;
      if ($urandom_range(9) != 0) b.etime = pick_hms();
      case ($urandom_range(9))
        0: b.mask = 7'h00;
        1: b.mask = 7'h7F;
        default: ;
      endcase
      b.en = ($urandom_range(6) != 0);
      b.once = ($urandom_range(99) < 35);
    end else if (pick < 80) begin
      b.op = OP_FIND;
      if (shadow_count > 0 && $urandom_range(4) == 0) begin
        // land exactly on a stored alarm to hit the still-due boundary
        b.now = 17'(hms_to_secs(shadow_table[$urandom_range(shadow_count - 1)].hms));
      end else if ($urandom_range(9) != 0) begin
        b.now = 17'($urandom_range(DaySecs - 1));
      end
    end else begin
      b.op = OP_DISABLE;
      if (shadow_count > 0 && $urandom_range(3) != 0) b.tidx = 5'($urandom_range(shadow_count - 1));
      b.tonce = ($urandom_range(7) != 0);
    end
    return b;
  endfunction

  // present one beat, hold it until taken
  task automatic drive_beat(input alarm_beat_t b, input bit typed, input alarm_result_t want,
                            input int unsigned idle_pct);
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(45, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_operation     <= b.op;
    in_entry_time    <= b.etime;
    in_repeat_mask   <= b.mask;
    in_entry_enabled <= b.en;
    in_entry_once    <= b.once;
    in_now_seconds   <= b.now;
    in_weekday       <= b.wday;
    in_trigger_index <= b.tidx;
    in_trigger_once  <= b.tonce;
    row_typed        <= typed;
    row_want         <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // check the result beat first, then queue the outcome of a beat taken at this edge
  always @(posedge clk) begin
    alarm_result_t want, got, predicted;
    if (rst_n && out_strobe) begin
      got = '{found: out_found, alarm_time: out_alarm_time, alarm_once: out_alarm_once,
              alarm_index: out_alarm_index, accepted: out_accepted};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result beat with nothing pending: %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found)
          note_failure($sformatf("found: exp %0d got %0d", want.found, got.found));
        if (got.alarm_time !== want.alarm_time)
          note_failure($sformatf("alarm_time: exp %0d got %0d", want.alarm_time, got.alarm_time));
        if (got.alarm_once !== want.alarm_once)
          note_failure($sformatf("alarm_once: exp %0d got %0d", want.alarm_once, got.alarm_once));
        if (got.alarm_index !== want.alarm_index)
          note_failure($sformatf("alarm_index: exp %0d got %0d", want.alarm_index,
                                 got.alarm_index));
        if (got.accepted !== want.accepted)
          note_failure($sformatf("accepted: exp %0d got %0d", want.accepted, got.accepted));
      end
    end
    if (rst_n && start && !busy) begin
      predicted = next_alarm_outcome('{op: op_t'(in_operation), etime: in_entry_time,
                                       mask: in_repeat_mask, en: in_entry_enabled,
                                       once: in_entry_once, now: in_now_seconds,
                                       wday: in_weekday, tidx: in_trigger_index,
                                       tonce: in_trigger_once});
      pending_results.push_back(row_typed ? row_want : predicted);
    end
  end

  initial begin
    alarm_beat_t b;
    int unsigned idle_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (directed_rows[i]) begin
      drive_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want, 0);
    end

    // fill the table to the brim, then push one past it
    b = '0;
    drive_beat(b, 1'b1, NoResult, 31);
    for (int i = 0; i < MaxEntries; i++) begin
      b = random_beat();
      b.op = OP_APPEND;
      b.en = 1'b1;
      b.once = (i == MaxEntries - 1) ? 1'b1 : b.once;
      b.etime = (i == MaxEntries - 1) ? 18'd0 : 18'($urandom_range(23, 1) * 10000);
      drive_beat(b, 1'b1, AppendOk, 31);
    end
    b.op = OP_APPEND;
    drive_beat(b, 1'b1, NoResult, 31);
    b = '0;
    b.op = OP_FIND;
    drive_beat(b, 1'b0, NoResult, 31);
    b.op = OP_DISABLE;
    b.tidx = 5'd31;
    b.tonce = 1'b1;
    drive_beat(b, 1'b1, NoResult, 31);
    b.op = OP_FIND;
    drive_beat(b, 1'b0, NoResult, 31);

    // random beats in idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 73;
        2: idle_pct = 31;
        default: idle_pct = 0;
      endcase
      repeat (98) drive_beat(random_beat(), 1'b0, NoResult, idle_pct);
    end
    start <= 1'b0;

    // drain, then allow a longest search for stray beats
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (MaxEntries + 16) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("weekly_alarm_next_finder_tb passed");
    end else begin
      $display("weekly_alarm_next_finder_tb failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #400000;
    $display("weekly_alarm_next_finder_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wanf_pkg.sv
hdl/wanf_ram.sv
hdl/wanf_ctrl.sv
hdl/wanf_dp.sv
hdl/weekly_alarm_next_finder.sv
sim/weekly_alarm_next_finder_tb.sv
